@@ hdl/ecd_pkg.sv @@
// shared constants, command/status types and calendar helpers for the epoch date converter
package ecd_pkg;

  localparam int SECONDS_BITS = 34;

  localparam int unsigned SECS_PER_DAY  = 24 * 3600;
  localparam int unsigned SECS_PER_HOUR = 3600;
  localparam int unsigned SECS_PER_MIN  = 60;

  // 86400 = 675 << 7: the low 7 bits pass straight into the time of day,
  // the upper bits are divided by 675 through a reciprocal multiply
  localparam int          DAY_SHIFT   = 7;
  localparam int unsigned DAY_ODD     = SECS_PER_DAY >> DAY_SHIFT;
  localparam int          ODD_BITS    = 10;
  localparam int          N_BITS      = SECONDS_BITS - DAY_SHIFT;
  localparam int          RECIP_SHIFT = N_BITS + ODD_BITS;
  localparam int          RECIP_BITS  = N_BITS + 1;
  localparam int          PROD_BITS   = N_BITS + RECIP_BITS;
  // rounded-up reciprocal; its excess times 675 stays below 2**ODD_BITS,
  // which keeps the quotient exact for every N_BITS-bit value
  localparam longint unsigned RECIP   = ((64'd1 << RECIP_SHIFT) + DAY_ODD - 1) / DAY_ODD;
  // 86400 > 2**16, so the day count always fits in SECONDS_BITS - 16 bits
  localparam int          DAY_BITS    = PROD_BITS - RECIP_SHIFT;
  localparam int          REM_BITS    = ODD_BITS + DAY_SHIFT;

  localparam int unsigned EPOCH_YEAR    = 1970;
  localparam int unsigned YEAR_BASE     = 1900;
  localparam int unsigned DAYS_COMMON   = 365;
  localparam int unsigned DAYS_LEAP     = 366;

  // residues of the epoch year, used to seed the leap rule counters
  localparam logic [9:0] YEAR_OFS_INIT = 10'(EPOCH_YEAR - YEAR_BASE);
  localparam logic [1:0] MOD4_INIT     = 2'(EPOCH_YEAR % 4);
  localparam logic [6:0] MOD100_INIT   = 7'(EPOCH_YEAR % 100);
  localparam logic [8:0] MOD400_INIT   = 9'(EPOCH_YEAR % 400);
  localparam logic [6:0] MOD100_LAST   = 7'(99);
  localparam logic [8:0] MOD400_LAST   = 9'(399);

  localparam logic [3:0] MON_JAN = 4'd0;
  localparam logic [3:0] MON_FEB = 4'd1;
  localparam logic [3:0] MON_APR = 4'd3;
  localparam logic [3:0] MON_JUN = 4'd5;
  localparam logic [3:0] MON_SEP = 4'd8;
  localparam logic [3:0] MON_NOV = 4'd10;
  localparam logic [3:0] MON_DEC = 4'd11;

  typedef struct packed {
    logic load;
    logic mul_step;
    logic fix_step;
    logic year_step;
    logic month_step;
    logic tod_step;
    logic load_out;
  } ecd_cmd_t;

  typedef struct packed {
    logic year_fits;
    logic month_fits;
    logic tod_done;
  } ecd_stat_t;

  function automatic logic [4:0] month_len(input logic [3:0] mon, input logic leap);
    logic [4:0] len;
    unique case (mon) inside
      MON_FEB:                          len = leap ? 5'd29 : 5'd28;
      MON_APR, MON_JUN, MON_SEP, MON_NOV: len = 5'd30;
      default:                          len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

@@ hdl/ecd_dp.sv @@
// datapath: reciprocal divide by 86400, year/month walk and time-of-day split
module ecd_dp import ecd_pkg::*; (
  input  logic                    clk,
  input  ecd_cmd_t                cmd,
  output ecd_stat_t               stat,
  input  logic [SECONDS_BITS-1:0] in_epoch_seconds,
  output logic [9:0]              out_year_since_1900,
  output logic [3:0]              out_month_index,
  output logic [4:0]              out_day_of_month,
  output logic [4:0]              out_hour_of_day,
  output logic [5:0]              out_minute_of_hour,
  output logic [5:0]              out_second_of_minute
);

  logic [SECONDS_BITS-1:0] sec_r;
  logic [DAY_BITS-1:0]     days_r;
  logic [REM_BITS-1:0]     rem_r;
  logic [9:0]              year_r;
  logic [1:0]              mod4_r;
  logic [6:0]              mod100_r;
  logic [8:0]              mod400_r;
  logic [3:0]              mon_r;
  logic [4:0]              hour_r;
  logic [5:0]              min_r;
  logic                    min_ph_r;

  logic [9:0]  year_o_r;
  logic [3:0]  mon_o_r;
  logic [4:0]  day_o_r;
  logic [4:0]  hour_o_r;
  logic [5:0]  min_o_r;
  logic [5:0]  sec_o_r;

  logic [N_BITS-1:0]    odd_num;
  logic [PROD_BITS-1:0] prod;
  logic [N_BITS-1:0]    back;
  logic [N_BITS-1:0]    odd_rem;
  logic                 leap;
  logic [DAY_BITS-1:0]  year_len;
  logic [DAY_BITS-1:0]  mon_len;
  logic                 hour_ge;
  logic                 min_ge;

  assign odd_num  = sec_r[SECONDS_BITS-1:DAY_SHIFT];
  assign prod     = PROD_BITS'(odd_num) * PROD_BITS'(RECIP);
  assign back     = N_BITS'(days_r) * N_BITS'(DAY_ODD);
  assign odd_rem  = odd_num - back;
  assign leap     = ((mod4_r == 2'd0) && (mod100_r != 7'd0)) || (mod400_r == 9'd0);
  assign year_len = leap ? DAY_BITS'(DAYS_LEAP) : DAY_BITS'(DAYS_COMMON);
  assign mon_len  = DAY_BITS'(month_len(mon_r, leap));
  assign hour_ge  = rem_r >= REM_BITS'(SECS_PER_HOUR);
  assign min_ge   = rem_r >= REM_BITS'(SECS_PER_MIN);

  assign stat.year_fits  = days_r < year_len;
  assign stat.month_fits = (days_r < mon_len) || (mon_r == MON_DEC);
  assign stat.tod_done   = min_ph_r && !min_ge;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      sec_r    <= in_epoch_seconds;
      year_r   <= YEAR_OFS_INIT;
      mod4_r   <= MOD4_INIT;
      mod100_r <= MOD100_INIT;
      mod400_r <= MOD400_INIT;
      mon_r    <= MON_JAN;
      hour_r   <= '0;
      min_r    <= '0;
      min_ph_r <= 1'b0;
    end
    if (cmd.mul_step) begin
      // day count straight off the reciprocal product
      days_r <= prod[PROD_BITS-1:RECIP_SHIFT];
    end
    if (cmd.fix_step) begin
      // remainder by 675 sits above the untouched low bits
      rem_r <= {odd_rem[ODD_BITS-1:0], sec_r[DAY_SHIFT-1:0]};
    end
    if (cmd.year_step) begin
      days_r   <= days_r - year_len;
      year_r   <= year_r + 10'd1;
      mod4_r   <= mod4_r + 2'd1;
      mod100_r <= (mod100_r == MOD100_LAST) ? 7'd0 : mod100_r + 7'd1;
      mod400_r <= (mod400_r == MOD400_LAST) ? 9'd0 : mod400_r + 9'd1;
    end
    if (cmd.month_step) begin
      days_r <= days_r - mon_len;
      mon_r  <= mon_r + 4'd1;
    end
    if (cmd.tod_step) begin
      if (!min_ph_r) begin
        if (hour_ge) begin
          rem_r  <= rem_r - REM_BITS'(SECS_PER_HOUR);
          hour_r <= hour_r + 5'd1;
        end else begin
          min_ph_r <= 1'b1;
        end
      end else if (min_ge) begin
        rem_r <= rem_r - REM_BITS'(SECS_PER_MIN);
        min_r <= min_r + 6'd1;
      end
    end
    if (cmd.load_out) begin
      year_o_r <= year_r;
      mon_o_r  <= mon_r;
      day_o_r  <= 5'(days_r + DAY_BITS'(1));
      hour_o_r <= hour_r;
      min_o_r  <= min_r;
      sec_o_r  <= rem_r[5:0];
    end
  end

  assign out_year_since_1900  = year_o_r;
  assign out_month_index      = mon_o_r;
  assign out_day_of_month     = day_o_r;
  assign out_hour_of_day      = hour_o_r;
  assign out_minute_of_hour   = min_o_r;
  assign out_second_of_minute = sec_o_r;

endmodule

@@ hdl/ecd_ctrl.sv @@
// controller: sequences division, calendar walk and result handoff
module ecd_ctrl import ecd_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  output ecd_cmd_t  cmd,
  input  ecd_stat_t stat
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_FIX,
    ST_YEAR,
    ST_MONTH,
    ST_TOD,
    ST_DONE
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    cmd           = '0;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd.mul_step = 1'b1;
        state_nxt    = ST_FIX;
      end
      ST_FIX: begin
        cmd.fix_step = 1'b1;
        state_nxt    = ST_YEAR;
      end
      ST_YEAR: begin
        cmd.tod_step = 1'b1;
        if (stat.year_fits) begin
          state_nxt = ST_MONTH;
        end else begin
          cmd.year_step = 1'b1;
        end
      end
      ST_MONTH: begin
        cmd.tod_step = 1'b1;
        if (stat.month_fits) begin
          state_nxt = ST_TOD;
        end else begin
          cmd.month_step = 1'b1;
        end
      end
      ST_TOD: begin
        cmd.tod_step = 1'b1;
        if (stat.tod_done) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

@@ hdl/epoch_seconds_to_civil_date.sv @@
// top level: epoch seconds to gregorian civil date and time
// Converts an unsigned count of seconds since 1970-01-01 00:00:00 (no time
// zone, no leap seconds) into year since 1900, month 0..11, day 1..31, hour,
// minute and second. One beat in gives one beat out. The block works on one
// conversion at a time: after an input beat is taken, in_ready stays low until
// the result has been moved into the output register. The output register
// holds a finished result until out_ready takes it, so a new input beat can be
// taken while the previous result still waits. After an input beat is taken,
// the conversion runs the reciprocal multiply that gives the day count (86400
// is 675 << 7), the remainder that gives the seconds of the day, the calendar
// walk and the load of the output register, which waits while the output
// register still holds an untaken result. The walk steps through each year
// after 1970 and each month before the result month; the time-of-day split
// into hours and minutes runs in parallel with the walk, and the longer of
// the two decides when the load follows. in_ready rises with out_valid. For late
// dates the year walk dominates; the largest 34-bit input falls in year 2514.
// Bits of the count are all used; no state is kept between conversions.
module epoch_seconds_to_civil_date import ecd_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [SECONDS_BITS-1:0] in_epoch_seconds,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [9:0]              out_year_since_1900,
  output logic [3:0]              out_month_index,
  output logic [4:0]              out_day_of_month,
  output logic [4:0]              out_hour_of_day,
  output logic [5:0]              out_minute_of_hour,
  output logic [5:0]              out_second_of_minute
);

  // command and status between sequencer and datapath
  ecd_cmd_t  cmd;
  ecd_stat_t stat;

  // sequencer: handshakes, day split steps, walk phases
  ecd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  // datapath: reciprocal day split, leap-rule counters, month table, output register
  ecd_dp u_dp (
    .clk                  (clk),
    .cmd                  (cmd),
    .stat                 (stat),
    .in_epoch_seconds     (in_epoch_seconds),
    .out_year_since_1900  (out_year_since_1900),
    .out_month_index      (out_month_index),
    .out_day_of_month     (out_day_of_month),
    .out_hour_of_day      (out_hour_of_day),
    .out_minute_of_hour   (out_minute_of_hour),
    .out_second_of_minute (out_second_of_minute)
  );

endmodule

@@ hdl/ecd_checker.sv @@
// port-level checks for the epoch date converter, bound to the top level
module ecd_checker import ecd_pkg::*; (
  input logic                    clk,
  input logic                    rst_n,
  input logic                    in_valid,
  input logic                    in_ready,
  input logic [SECONDS_BITS-1:0] in_epoch_seconds,
  input logic                    out_valid,
  input logic                    out_ready,
  input logic [9:0]              out_year_since_1900,
  input logic [3:0]              out_month_index,
  input logic [4:0]              out_day_of_month,
  input logic [4:0]              out_hour_of_day,
  input logic [5:0]              out_minute_of_hour,
  input logic [5:0]              out_second_of_minute
);

  // an offered input beat stays put until taken
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid && $stable(in_epoch_seconds))
    else $error("input beat changed before accept");

  // a result beat stays offered until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped before accept");

  // stalled result does not change
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_year_since_1900) && $stable(out_month_index)
      && $stable(out_day_of_month) && $stable(out_hour_of_day)
      && $stable(out_minute_of_hour) && $stable(out_second_of_minute))
    else $error("result beat changed while stalled");

  // converter is busy right after taking a beat
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second beat taken during conversion");

  // every result field lies in its legal range
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_month_index <= MON_DEC && out_day_of_month >= 5'd1
      && out_day_of_month <= 5'd31 && out_hour_of_day <= 5'd23
      && out_minute_of_hour <= 6'd59 && out_second_of_minute <= 6'd59
      && out_year_since_1900 >= YEAR_OFS_INIT)
    else $error("result field out of range");

endmodule

bind epoch_seconds_to_civil_date ecd_checker u_ecd_checker (
  .clk                  (clk),
  .rst_n                (rst_n),
  .in_valid             (in_valid),
  .in_ready             (in_ready),
  .in_epoch_seconds     (in_epoch_seconds),
  .out_valid            (out_valid),
  .out_ready            (out_ready),
  .out_year_since_1900  (out_year_since_1900),
  .out_month_index      (out_month_index),
  .out_day_of_month     (out_day_of_month),
  .out_hour_of_day      (out_hour_of_day),
  .out_minute_of_hour   (out_minute_of_hour),
  .out_second_of_minute (out_second_of_minute)
);
